// ----- hdl/sss_pkg.sv -----
// Shared types and constants for the shooter servo sequencer.
// Used by shooter_servo_sequencer_unit and its testbench; no other dependencies.
`default_nettype none

package sss_pkg;

    // Field widths
    localparam int unsigned PhaseW   = 10;
    localparam int unsigned BurstW   = 6;
    localparam int unsigned WheelW   = 11;
    localparam int unsigned GateW    = 12;
    localparam int unsigned FeederW  = 11;
    localparam int unsigned ReloadW  = 10;
    localparam int unsigned LaunchW  = 11;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 11;
    localparam int unsigned InDataW  = 8;   // six switch bits, padded to a byte
    localparam int unsigned OutDataW = 72;  // 67 bits of result, padded

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_FIRE_PHASE_END   = 3'd0,
        CFG_HOLD_PHASE_END   = 3'd1,
        CFG_RELOAD_PHASE_END = 3'd2,
        CFG_SETTLE_PHASE_END = 3'd3,
        CFG_BURST_PERIOD     = 3'd4,
        CFG_BURST_ON_TICKS   = 3'd5,
        CFG_SMALL_WHEEL_RUN  = 3'd6,
        CFG_BIG_WHEEL_RUN    = 3'd7
    } cfg_index_t;

    // Register defaults
    localparam logic [PhaseW-1:0] FIRE_PHASE_END_RST   = 10'd25;
    localparam logic [PhaseW-1:0] HOLD_PHASE_END_RST   = 10'd50;
    localparam logic [PhaseW-1:0] RELOAD_PHASE_END_RST = 10'd80;
    localparam logic [PhaseW-1:0] SETTLE_PHASE_END_RST = 10'd105;
    localparam logic [BurstW-1:0] BURST_PERIOD_RST     = 6'd18;
    localparam logic [BurstW-1:0] BURST_ON_TICKS_RST   = 6'd10;
    localparam logic [WheelW-1:0] SMALL_WHEEL_RUN_RST  = 11'd2000;
    localparam logic [WheelW-1:0] BIG_WHEEL_RUN_RST    = 11'd1300;

    // PWM compare values
    localparam logic [WheelW-1:0]  PWM_MIN        = 11'd1000;
    localparam logic [WheelW-1:0]  PWM_MAX        = 11'd2000;
    localparam logic [GateW-1:0]   GATE_SMALL     = 12'd1000;
    localparam logic [GateW-1:0]   GATE_BIG       = 12'd2400;
    localparam logic [GateW-1:0]   GATE_RST       = 12'd1500;
    localparam logic [FeederW-1:0] FEEDER_IDLE    = 11'd1000;
    localparam logic [FeederW-1:0] FEEDER_FAST    = 11'd1150;
    localparam logic [ReloadW-1:0] RELOAD_REST    = 10'd700;
    localparam logic [ReloadW-1:0] RELOAD_PUSH    = 10'd1000;
    localparam logic [LaunchW-1:0] LAUNCH_RELEASE = 11'd1500;
    localparam logic [LaunchW-1:0] LAUNCH_HOLD    = 11'd2000;

    // Shot counter fold
    localparam logic [PhaseW-1:0] SHOT_WRAP = 10'd1000;
    localparam logic [PhaseW-1:0] SHOT_FOLD = 10'd500;

    typedef struct packed {
        logic fire_switch;
        logic feed_burst_switch;
        logic feed_idle_switch;
        logic run_big_switch;
        logic run_small_switch;
        logic stop_switch;
    } tick_t;

    typedef struct packed {
        logic               shot_ready;
        logic [LaunchW-1:0] launch_servo_pwm;
        logic [ReloadW-1:0] reload_servo_pwm;
        logic [FeederW-1:0] feeder_pwm;
        logic [GateW-1:0]   gate_pwm;
        logic [WheelW-1:0]  big_wheel_pwm;
        logic [WheelW-1:0]  small_wheel_pwm;
    } result_t;

    function automatic logic [WheelW-1:0] clamp_pwm(input logic [WheelW-1:0] v);
        logic [WheelW-1:0] r;
        r = v;
        if (v < PWM_MIN)
            r = PWM_MIN;
        else if (v > PWM_MAX)
            r = PWM_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/shooter_servo_sequencer_unit.sv -----
// Shooter servo sequencer top level: mode, feeder and shot-phase logic.
// Depends on sss_pkg for types, register indexes and PWM constants.
`default_nettype none

// Usage
// -----
// Input stream (s_axis_*): one beat is one control tick carrying six switch
// bits. Output stream (m_axis_*): one beat per input beat with the six held
// PWM compare values and the shot ready flag, after that tick's update.
// Config port (cfg_we/cfg_index/cfg_data): writes one of eight registers per
// clock, no back-pressure and no read-back; write only while the block is
// idle. All eight indexes are mapped.
// Output: an accepted beat is registered into the output register at the
// accepting edge. Throughput: one beat per clock while m_axis_tready drains
// the output; the whole tick update is a single level of compare/increment
// logic between the state registers and the output register.
// Reset: all state registers take their defaults; ready is low, so one shot
// sequence runs by itself over the first ticks. No output beat is pending.
// Stall: when m_axis_tready is low and a beat is held, s_axis_tready drops;
// while the output register is empty or being drained, input beats flow on
// every cycle.
module shooter_servo_sequencer_unit (
    input  wire                           clk,
    input  wire                           rst_n,
    // [0] stop_switch, [1] run_small_switch, [2] run_big_switch,
    // [3] feed_idle_switch, [4] feed_burst_switch, [5] fire_switch, [7:6] zero
    input  wire  [sss_pkg::InDataW-1:0]   s_axis_tdata,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // [10:0] small_wheel_pwm, [21:11] big_wheel_pwm, [33:22] gate_pwm,
    // [44:34] feeder_pwm, [54:45] reload_servo_pwm, [65:55] launch_servo_pwm,
    // [66] shot_ready, [71:67] zero
    output logic [sss_pkg::OutDataW-1:0]  m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    input  wire                           cfg_we,
    input  wire  [sss_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire  [sss_pkg::CfgDataW-1:0]  cfg_data
);
    import sss_pkg::*;

    // Configuration registers
    logic [PhaseW-1:0] fire_phase_end_reg, hold_phase_end_reg;
    logic [PhaseW-1:0] reload_phase_end_reg, settle_phase_end_reg;
    logic [BurstW-1:0] burst_period_reg, burst_on_ticks_reg;
    logic [WheelW-1:0] small_wheel_run_reg, big_wheel_run_reg;

    // Tick state
    logic               wheels_on_reg, wheels_on_next;
    logic [BurstW-1:0]  burst_count_reg, burst_count_next;
    logic [PhaseW-1:0]  shot_count_reg, shot_count_next;
    logic               ready_flag_reg, ready_flag_next;
    logic [WheelW-1:0]  small_wheel_hold_reg, small_wheel_hold_next;
    logic [WheelW-1:0]  big_wheel_hold_reg, big_wheel_hold_next;
    logic [GateW-1:0]   gate_hold_reg, gate_hold_next;
    logic [FeederW-1:0] feeder_hold_reg, feeder_hold_next;
    logic [ReloadW-1:0] reload_hold_reg, reload_hold_next;
    logic [LaunchW-1:0] launch_hold_reg, launch_hold_next;

    // Output stage
    logic                m_valid_reg;
    logic [OutDataW-1:0] m_data_reg;

    tick_t              tick;
    result_t            result;
    logic               in_beat;
    logic [BurstW:0]    burst_inc;
    logic [PhaseW-1:0]  shot_inc;
    logic               wheels_tmp;

    assign tick          = tick_t'(s_axis_tdata[$bits(tick_t)-1:0]);
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ---------------- config writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_phase_end_reg   <= FIRE_PHASE_END_RST;
            hold_phase_end_reg   <= HOLD_PHASE_END_RST;
            reload_phase_end_reg <= RELOAD_PHASE_END_RST;
            settle_phase_end_reg <= SETTLE_PHASE_END_RST;
            burst_period_reg     <= BURST_PERIOD_RST;
            burst_on_ticks_reg   <= BURST_ON_TICKS_RST;
            small_wheel_run_reg  <= SMALL_WHEEL_RUN_RST;
            big_wheel_run_reg    <= BIG_WHEEL_RUN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FIRE_PHASE_END:   fire_phase_end_reg   <= cfg_data[PhaseW-1:0];
                CFG_HOLD_PHASE_END:   hold_phase_end_reg   <= cfg_data[PhaseW-1:0];
                CFG_RELOAD_PHASE_END: reload_phase_end_reg <= cfg_data[PhaseW-1:0];
                CFG_SETTLE_PHASE_END: settle_phase_end_reg <= cfg_data[PhaseW-1:0];
                CFG_BURST_PERIOD:     burst_period_reg     <= cfg_data[BurstW-1:0];
                CFG_BURST_ON_TICKS:   burst_on_ticks_reg   <= cfg_data[BurstW-1:0];
                CFG_SMALL_WHEEL_RUN:  small_wheel_run_reg  <= cfg_data[WheelW-1:0];
                CFG_BIG_WHEEL_RUN:    big_wheel_run_reg    <= cfg_data[WheelW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- tick update ----------------
    // Order within a tick: stop, run small, run big (last wins), feeder,
    // fire, then one step of the shot sequence.
    always_comb
    begin
        wheels_tmp            = wheels_on_reg;
        small_wheel_hold_next = small_wheel_hold_reg;
        big_wheel_hold_next   = big_wheel_hold_reg;
        gate_hold_next        = gate_hold_reg;
        burst_count_next      = burst_count_reg;
        feeder_hold_next      = feeder_hold_reg;
        shot_count_next       = shot_count_reg;
        ready_flag_next       = ready_flag_reg;
        reload_hold_next      = reload_hold_reg;
        launch_hold_next      = launch_hold_reg;
        burst_inc             = '0;
        shot_inc              = '0;

        if (tick.stop_switch)
        begin
            small_wheel_hold_next = PWM_MIN;
            big_wheel_hold_next   = PWM_MIN;
            gate_hold_next        = GATE_SMALL;
            wheels_tmp            = 1'b0;
        end
        if (tick.run_small_switch || tick.run_big_switch)
        begin
            small_wheel_hold_next = clamp_pwm(small_wheel_run_reg);
            big_wheel_hold_next   = clamp_pwm(big_wheel_run_reg);
            gate_hold_next        = tick.run_big_switch ? GATE_BIG : GATE_SMALL;
            wheels_tmp            = 1'b1;
        end
        wheels_on_next = wheels_tmp;

        // Feeder: idle clears, burst advances the count (wheels running only)
        if (tick.feed_idle_switch)
        begin
            feeder_hold_next = FEEDER_IDLE;
            burst_count_next = '0;
        end
        if (tick.feed_burst_switch && wheels_tmp)
        begin
            burst_inc = {1'b0, burst_count_next} + {{BurstW{1'b0}}, 1'b1};
            if (burst_inc > {1'b0, burst_period_reg})
                burst_count_next = '0;
            else
                burst_count_next = burst_inc[BurstW-1:0];
            feeder_hold_next = (burst_count_next < burst_on_ticks_reg) ?
                               FEEDER_FAST : FEEDER_IDLE;
        end

        // Fire restarts the sequence
        if (tick.fire_switch && wheels_tmp && ready_flag_reg)
        begin
            shot_count_next = '0;
            ready_flag_next = 1'b0;
        end

        // Shot sequence: count ticks, phase ends are checked in list order
        if (!ready_flag_next)
        begin
            shot_inc = shot_count_next + {{(PhaseW-1){1'b0}}, 1'b1};
            if (shot_inc >= SHOT_WRAP)
                shot_inc = SHOT_FOLD;
            shot_count_next = shot_inc;
            priority if (shot_inc < fire_phase_end_reg)
            begin
                reload_hold_next = RELOAD_REST;
                launch_hold_next = LAUNCH_RELEASE;
            end
            else if (shot_inc < hold_phase_end_reg)
            begin
                reload_hold_next = RELOAD_REST;
                launch_hold_next = LAUNCH_HOLD;
            end
            else if (shot_inc < reload_phase_end_reg)
            begin
                reload_hold_next = RELOAD_PUSH;
                launch_hold_next = LAUNCH_HOLD;
            end
            else if (shot_inc < settle_phase_end_reg)
            begin
                reload_hold_next = RELOAD_REST;
                launch_hold_next = LAUNCH_HOLD;
            end
            else
            begin
                ready_flag_next = 1'b1;
            end
        end

        result.small_wheel_pwm  = small_wheel_hold_next;
        result.big_wheel_pwm    = big_wheel_hold_next;
        result.gate_pwm         = gate_hold_next;
        result.feeder_pwm       = feeder_hold_next;
        result.reload_servo_pwm = reload_hold_next;
        result.launch_servo_pwm = launch_hold_next;
        result.shot_ready       = ready_flag_next;
    end

    // ---------------- state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheels_on_reg        <= 1'b0;
            burst_count_reg      <= '0;
            shot_count_reg       <= '0;
            ready_flag_reg       <= 1'b0;
            small_wheel_hold_reg <= PWM_MIN;
            big_wheel_hold_reg   <= PWM_MIN;
            gate_hold_reg        <= GATE_RST;
            feeder_hold_reg      <= FEEDER_IDLE;
            reload_hold_reg      <= RELOAD_PUSH;
            launch_hold_reg      <= LAUNCH_HOLD;
        end
        else if (in_beat)
        begin
            wheels_on_reg        <= wheels_on_next;
            burst_count_reg      <= burst_count_next;
            shot_count_reg       <= shot_count_next;
            ready_flag_reg       <= ready_flag_next;
            small_wheel_hold_reg <= small_wheel_hold_next;
            big_wheel_hold_reg   <= big_wheel_hold_next;
            gate_hold_reg        <= gate_hold_next;
            feeder_hold_reg      <= feeder_hold_next;
            reload_hold_reg      <= reload_hold_next;
            launch_hold_reg      <= launch_hold_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (in_beat)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            m_data_reg <= {{(OutDataW-$bits(result_t)){1'b0}}, result};
    end

    // ---------------- assertions ----------------
    // Shot counter folds before it reaches the wrap value
    a_shot_range: assert property (@(posedge clk) disable iff (!rst_n)
        shot_count_reg < SHOT_WRAP)
        else $error("shot counter out of range");

    // While a sequence runs, every tick moves the counter
    a_shot_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && !ready_flag_reg |=> shot_count_reg != $past(shot_count_reg))
        else $error("shot counter stuck while not ready");

    // Ready holds, and the shot counter and launch servo stay put, unless a fire comes in
    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && ready_flag_reg && !tick.fire_switch |=>
            ready_flag_reg && $stable(shot_count_reg) && $stable(launch_hold_reg))
        else $error("ready state disturbed without fire");

    // Gate only ever holds one of its three positions
    a_gate_pos: assert property (@(posedge clk) disable iff (!rst_n)
        gate_hold_reg == GATE_SMALL || gate_hold_reg == GATE_BIG ||
        gate_hold_reg == GATE_RST)
        else $error("gate compare value invalid");

    // Output ready bit reflects the state after the accepted tick
    a_out_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> m_axis_tdata[$bits(result_t)-1] == ready_flag_reg)
        else $error("output ready bit disagrees with state");

endmodule

`default_nettype wire

// ----- dv/tb_shooter_servo_sequencer_unit.sv -----
// Testbench for shooter_servo_sequencer_unit: random and directed switch ticks,
// checked beat by beat against a predictor of the shooter state.
// Depends on sss_pkg and the shooter_servo_sequencer_unit RTL only.
`timescale 1ns / 1ps

module tb_shooter_servo_sequencer_unit;

    import sss_pkg::*;

    localparam int unsigned HALF_PERIOD     = 5;
    localparam int unsigned RESET_CYCLES    = 9;
    localparam int unsigned MAX_IDLE        = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 250;
    localparam int unsigned HOLD_OFF_AFTER  = 400;    // results seen before the long stall
    localparam int unsigned CYCLE_LIMIT     = 200000;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index     = '0;
    logic [CfgDataW-1:0] cfg_data      = '0;

    always #HALF_PERIOD clk = ~clk;

    shooter_servo_sequencer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Register shadow: what the DUT should hold after each write
    // ------------------------------------------------------------------
    logic [PhaseW-1:0] fire_end   = FIRE_PHASE_END_RST;
    logic [PhaseW-1:0] hold_end   = HOLD_PHASE_END_RST;
    logic [PhaseW-1:0] reload_end = RELOAD_PHASE_END_RST;
    logic [PhaseW-1:0] settle_end = SETTLE_PHASE_END_RST;
    logic [BurstW-1:0] burst_wrap = BURST_PERIOD_RST;
    logic [BurstW-1:0] burst_fast = BURST_ON_TICKS_RST;
    logic [WheelW-1:0] small_run  = SMALL_WHEEL_RUN_RST;
    logic [WheelW-1:0] big_run    = BIG_WHEEL_RUN_RST;

    // ------------------------------------------------------------------
    // Shooter state as the predictor sees it
    // ------------------------------------------------------------------
    logic               wheels_spun = 1'b0;
    logic [BurstW-1:0]  burst_phase = '0;
    logic [PhaseW-1:0]  shot_tick   = '0;
    logic               can_fire    = 1'b0;   // low after reset: one shot runs by itself
    logic [WheelW-1:0]  small_cmp   = PWM_MIN;
    logic [WheelW-1:0]  big_cmp     = PWM_MIN;
    logic [GateW-1:0]   gate_cmp    = GATE_RST;
    logic [FeederW-1:0] feeder_cmp  = FEEDER_IDLE;
    logic [ReloadW-1:0] reload_cmp  = RELOAD_PUSH;
    logic [LaunchW-1:0] launch_cmp  = LAUNCH_HOLD;

    // Stimulus and scoreboard
    tick_t       pending_ticks[$];
    result_t     expected_outputs[$];
    int unsigned ticks_offered  = 0;
    int unsigned ticks_taken    = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned settings_used  = 1;   // reset defaults count as the first
    int unsigned shots_started  = 0;
    int unsigned ready_returns  = 0;
    int unsigned burst_wraps    = 0;
    int unsigned cycle_count    = 0;

    // Pacing knobs, changed per phase by the sequence below
    int unsigned src_idle_max  = 0;
    int unsigned sink_idle_max = 0;
    int unsigned src_gap       = 0;
    int unsigned sink_gap      = 0;
    int unsigned results_paced = 0;
    logic        sink_hold     = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [WheelW-1:0] wheel_limit(input logic [WheelW-1:0] v);
        if (v < PWM_MIN)
            return PWM_MIN;
        if (v > PWM_MAX)
            return PWM_MAX;
        return v;
    endfunction

    // Applies one tick to the shadow state and returns the beat it produces.
    // Rule order matters: stop, run small, run big, feeder, fire, shot phase.
    function automatic result_t advance_tick(input tick_t t);
        result_t     r;
        int unsigned next_burst;
        int unsigned next_shot;

        if (t.stop_switch) begin
            small_cmp   = PWM_MIN;
            big_cmp     = PWM_MIN;
            gate_cmp    = GATE_SMALL;
            wheels_spun = 1'b0;
        end
        if (t.run_small_switch) begin
            small_cmp   = wheel_limit(small_run);
            big_cmp     = wheel_limit(big_run);
            gate_cmp    = GATE_SMALL;
            wheels_spun = 1'b1;
        end
        if (t.run_big_switch) begin
            small_cmp   = wheel_limit(small_run);
            big_cmp     = wheel_limit(big_run);
            gate_cmp    = GATE_BIG;
            wheels_spun = 1'b1;
        end

        if (t.feed_idle_switch) begin
            feeder_cmp  = FEEDER_IDLE;
            burst_phase = '0;
        end
        if (t.feed_burst_switch && wheels_spun) begin
            next_burst = burst_phase + 1;
            if (next_burst > burst_wrap) begin
                next_burst = 0;
                burst_wraps++;
            end
            burst_phase = BurstW'(next_burst);
            feeder_cmp  = (burst_phase < burst_fast) ? FEEDER_FAST : FEEDER_IDLE;
        end

        if (t.fire_switch && wheels_spun && can_fire) begin
            shot_tick = '0;
            can_fire  = 1'b0;
            shots_started++;
        end

        if (!can_fire) begin
            next_shot = shot_tick + 1;
            if (next_shot >= SHOT_WRAP)
                next_shot = SHOT_FOLD;
            shot_tick = PhaseW'(next_shot);
            // First matching end wins, so out-of-order ends hide later phases
            if (shot_tick < fire_end) begin
                reload_cmp = RELOAD_REST;
                launch_cmp = LAUNCH_RELEASE;
            end else if (shot_tick < hold_end) begin
                reload_cmp = RELOAD_REST;
                launch_cmp = LAUNCH_HOLD;
            end else if (shot_tick < reload_end) begin
                reload_cmp = RELOAD_PUSH;
                launch_cmp = LAUNCH_HOLD;
            end else if (shot_tick < settle_end) begin
                reload_cmp = RELOAD_REST;
                launch_cmp = LAUNCH_HOLD;
            end else begin
                can_fire = 1'b1;
                ready_returns++;
            end
        end

        r.small_wheel_pwm  = small_cmp;
        r.big_wheel_pwm    = big_cmp;
        r.gate_pwm         = gate_cmp;
        r.feeder_pwm       = feeder_cmp;
        r.reload_servo_pwm = reload_cmp;
        r.launch_servo_pwm = launch_cmp;
        r.shot_ready       = can_fire;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued ticks on the falling edge. A new tick goes
    // out only once the previous one was taken, after its drawn gap.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end
        else if (ticks_offered == ticks_taken) begin
            if (src_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap--;
            end
            else if (pending_ticks.size() != 0) begin
                s_axis_tdata  <= InDataW'(pending_ticks.pop_front());
                s_axis_tvalid <= 1'b1;
                ticks_offered++;
                src_gap = $urandom_range(0, src_idle_max);
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready: a fresh stall is drawn after every accepted beat;
    // sink_hold overrides everything during the long back-pressure stretch.
    always @(negedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (results_seen != results_paced) begin
                results_paced = results_seen;
                sink_gap      = $urandom_range(0, sink_idle_max);
            end
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0) begin
                m_axis_tready <= 1'b0;
                sink_gap--;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off once traffic is well under way; the driver keeps
    // offering so the output register fills and the input side stalls.
    initial begin
        wait (results_seen >= HOLD_OFF_AFTER);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: output beats are checked before this edge's input beat is
    // predicted, so a beat with nothing outstanding is caught.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        result_t got;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
                if (expected_outputs.size() == 0) begin
                    $error("output beat with no tick outstanding: %h", m_axis_tdata);
                    mismatches++;
                end
                else begin
                    want = expected_outputs.pop_front();
                    check_field("small_wheel_pwm", want.small_wheel_pwm, got.small_wheel_pwm);
                    check_field("big_wheel_pwm", want.big_wheel_pwm, got.big_wheel_pwm);
                    check_field("gate_pwm", want.gate_pwm, got.gate_pwm);
                    check_field("feeder_pwm", want.feeder_pwm, got.feeder_pwm);
                    check_field("reload_servo_pwm", want.reload_servo_pwm,
                                got.reload_servo_pwm);
                    check_field("launch_servo_pwm", want.launch_servo_pwm,
                                got.launch_servo_pwm);
                    check_field("shot_ready", want.shot_ready, got.shot_ready);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ticks_taken++;
                expected_outputs.push_back(
                    advance_tick(tick_t'(s_axis_tdata[$bits(tick_t)-1:0])));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly plausible operator input: wheels kept running, fire and burst
    // pressed often, stop and feeder reset rare. One tick in ten is noise.
    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(0, 9) == 0) begin
            t = tick_t'(6'($urandom_range(0, 63)));
        end
        else begin
            t.stop_switch       = ($urandom_range(0, 11) == 0);
            t.run_small_switch  = ($urandom_range(0, 5) == 0);
            t.run_big_switch    = ($urandom_range(0, 5) == 0);
            t.feed_idle_switch  = ($urandom_range(0, 9) == 0);
            t.feed_burst_switch = ($urandom_range(0, 1) == 0);
            t.fire_switch       = ($urandom_range(0, 2) == 0);
        end
        return t;
    endfunction

    // Returns once every queued tick was taken and every beat checked
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || ticks_offered != ticks_taken ||
               expected_outputs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgDataW'(value);
        case (idx)
            CFG_FIRE_PHASE_END:   fire_end   = PhaseW'(value);
            CFG_HOLD_PHASE_END:   hold_end   = PhaseW'(value);
            CFG_RELOAD_PHASE_END: reload_end = PhaseW'(value);
            CFG_SETTLE_PHASE_END: settle_end = PhaseW'(value);
            CFG_BURST_PERIOD:     burst_wrap = BurstW'(value);
            CFG_BURST_ON_TICKS:   burst_fast = BurstW'(value);
            CFG_SMALL_WHEEL_RUN:  small_run  = WheelW'(value);
            CFG_BIG_WHEEL_RUN:    big_run    = WheelW'(value);
            default: ;
        endcase
    endtask

    // Only called with the pipe drained
    task automatic apply_settings(input int unsigned fe, input int unsigned he,
                                  input int unsigned re, input int unsigned se,
                                  input int unsigned bp, input int unsigned bo,
                                  input int unsigned sr, input int unsigned br);
        write_reg(CFG_FIRE_PHASE_END, fe);
        write_reg(CFG_HOLD_PHASE_END, he);
        write_reg(CFG_RELOAD_PHASE_END, re);
        write_reg(CFG_SETTLE_PHASE_END, se);
        write_reg(CFG_BURST_PERIOD, bp);
        write_reg(CFG_BURST_ON_TICKS, bo);
        write_reg(CFG_SMALL_WHEEL_RUN, sr);
        write_reg(CFG_BIG_WHEEL_RUN, br);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_ticks(input int unsigned count, input int unsigned src_max,
                             input int unsigned sink_max);
        @(posedge clk);
        src_idle_max  = src_max;
        sink_idle_max = sink_max;
        repeat (count) pending_ticks.push_back(random_tick());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // Bits, low to high: stop, run small, run big, feed idle, burst, fire
        logic [5:0]  opening [20];
        int unsigned fe, he, re, se;

        opening = '{
            6'b000000,  // idle: start-up shot sequence runs alone
            6'b100000,  // fire with wheels off
            6'b010000,  // burst with wheels off has no effect
            6'b000001,  // stop
            6'b000010,  // run small
            6'b010000,  // burst
            6'b010000,
            6'b001000,  // feeder reset
            6'b000100,  // run big
            6'b000111,  // stop, small and big together: big wins
            6'b000011,  // stop then small: small wins
            6'b000101,  // stop then big
            6'b011000,  // feeder reset and burst in one tick
            6'b100010,  // fire before ready
            6'b111111,  // everything
            6'b000001,
            6'b110001,  // stop with burst and fire
            6'b000110,  // small then big
            6'b010100,  // big with burst
            6'b000000
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks at reset defaults, no idling on either side
        @(posedge clk);
        foreach (opening[i])
            pending_ticks.push_back(tick_t'(opening[i]));
        wait_drained();
        run_ticks(180, MAX_IDLE, MAX_IDLE);

        // Short phases, burst period zero, wheel run values clamped both ways
        apply_settings(5, 10, 15, 20, 0, 0, 0, 2047);
        run_ticks(160, MAX_IDLE, 0);

        // All maxima: the fire phase end hides every later phase
        apply_settings(1023, 1023, 1023, 1023, 63, 63, 2047, 999);
        run_ticks(120, 0, MAX_IDLE);

        // Unordered phase ends, shortest burst
        apply_settings(30, 10, 60, 40, 1, 1, 1500, 1000);
        run_ticks(160, MAX_IDLE, MAX_IDLE);

        // All ends zero: ready again within the very tick that fires
        apply_settings(0, 0, 0, 0, 2, 1, 2000, 2001);
        run_ticks(160, 0, 0);

        // Settle end beyond the fold: counter cycles 500..999, never ready
        apply_settings(100, 300, 600, 1000, 31, 16, 1000, 1999);
        run_ticks(160, MAX_IDLE, MAX_IDLE);

        // Random settings, mostly ordered and short enough to finish shots
        for (int k = 0; k < 4; k++) begin
            fe = $urandom_range(0, 40);
            he = fe + $urandom_range(0, 40);
            re = he + $urandom_range(0, 40);
            se = re + $urandom_range(0, 40);
            if ($urandom_range(0, 3) == 0) begin
                fe = $urandom_range(0, 1023);
                he = $urandom_range(0, 1023);
                re = $urandom_range(0, 1023);
                se = $urandom_range(0, 1023);
            end
            apply_settings(fe, he, re, se, $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(900, 2047), $urandom_range(900, 2047));
            run_ticks(100, $urandom_range(0, 1) * MAX_IDLE, $urandom_range(0, 1) * MAX_IDLE);
        end

        // Back to the power-up values, written explicitly
        apply_settings(25, 50, 80, 105, 18, 10, 2000, 1300);
        run_ticks(100, MAX_IDLE, MAX_IDLE);

        repeat (5) @(posedge clk);
        $display("Checked %0d beats for %0d ticks over %0d register settings, %0d mismatches.",
                 results_seen, ticks_taken, settings_used, mismatches);
        $display("Shots fired %0d, sequences completed %0d, burst counter wraps %0d.",
                 shots_started, ready_returns, burst_wraps);
        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
